FILE: design/dtwsl_pkg.sv
`default_nettype none

package dtwsl_pkg;

   // field widths
   localparam int unsigned FREQ_W  = 27;
   localparam int unsigned CTRL_W  = 2;
   localparam int unsigned PHASE_W = 5;
   localparam int unsigned TW_W    = 32;

   // serial word: tuning word, control bits, power-down bit, phase
   localparam int unsigned WORD_W  = TW_W + CTRL_W + 1 + PHASE_W;
   // results per item: every word bit plus the update strobe
   localparam int unsigned RUN_LEN = WORD_W + 1;
   localparam int unsigned CNT_W   = $clog2(RUN_LEN + 1);

   // full-scale clock in hertz; requests above it saturate
   localparam logic [FREQ_W-1:0] FULL_SCALE_HZ = FREQ_W'(125000000);

   // tw = floor(f * 2^31 / 125e6) = floor(f * 2^25 / 5^9)
   localparam int unsigned REM_W = 22;
   localparam logic [REM_W-1:0] DIVISOR = REM_W'(1953125);
   // floor(2^52 / 5^9); estimate is (f * RECIP) >> 27, short by at most one
   localparam int unsigned RECIP_SHIFT = 27;
   localparam logic [TW_W-1:0] RECIP = 32'd2305843009;
   localparam int unsigned PROD_W = FREQ_W + TW_W;

   // strobe kinds
   localparam logic KIND_WORD_CLOCK = 1'b0;
   localparam logic KIND_FREQ_UPDATE = 1'b1;

   // fields that ride along the arithmetic stages
   typedef struct packed {
      logic [CTRL_W-1:0]  control_bits;
      logic               power_down;
      logic [PHASE_W-1:0] phase;
   } side_type;

endpackage

`default_nettype wire

FILE: design/dds_tuning_word_serial_load.sv
// An accepted item moves through the four registered stages into the output shifter, which then
// gives 41 results, one per cycle with no gap (40 word bits, then the update strobe).
// The one-bit-per-cycle output shifter sets the item rate;
// the next item runs through the four arithmetic stages while the previous one shifts out.
// Reset: synchronous, active high; clears the stage valid bits and the result counter.
`default_nettype none

module dds_tuning_word_serial_load (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [dtwsl_pkg::FREQ_W-1:0]   req_freq_hz,
   input  wire logic [dtwsl_pkg::CTRL_W-1:0]   req_control_bits,
   input  wire logic                           req_power_down,
   input  wire logic [dtwsl_pkg::PHASE_W-1:0]  req_phase,
   output logic                                rsp_valid,
   output logic                                rsp_serial_bit,
   output logic                                rsp_strobe_kind,
   output logic                                rsp_last
);

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;

   // stage payloads
   logic [dtwsl_pkg::FREQ_W-1:0]  s1_freq_ff, s1_freq_in;
   dtwsl_pkg::side_type           s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff;
   dtwsl_pkg::side_type           s1_side_in;
   logic [dtwsl_pkg::TW_W-1:0]    s2_est_ff, s2_est_in;
   logic [dtwsl_pkg::TW_W-1:0]    s3_est_ff;
   logic [dtwsl_pkg::REM_W-1:0]   s3_low_ff, s3_low_in;
   logic [dtwsl_pkg::TW_W-1:0]    s4_tw_ff, s4_tw_in;

   // output shifter
   logic [dtwsl_pkg::WORD_W-1:0]  shift_ff, shift_in;
   logic [dtwsl_pkg::CNT_W-1:0]   count_ff, count_in;

   // stage advance chain
   logic shifter_free;
   logic adv1, adv2, adv3, adv4;
   logic ser_load;

   // arithmetic intermediates
   logic [dtwsl_pkg::PROD_W-1:0]  est_prod;
   logic [dtwsl_pkg::REM_W+21-1:0] low_prod;
   logic [dtwsl_pkg::REM_W-1:0]   remainder;
   logic                          round_up;

   // a stage moves when it is empty or the next one moves
   assign shifter_free = (count_ff <= dtwsl_pkg::CNT_W'(1));
   assign adv4 = !s4_valid_ff || shifter_free;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign busy = !adv1;
   assign ser_load = s4_valid_ff && shifter_free;

   // stage 1: capture and saturate the request
   always_comb begin
      s1_valid_in = adv1 ? start : s1_valid_ff;
      s1_freq_in  = s1_freq_ff;
      s1_side_in  = s1_side_ff;
      if (adv1) begin
         s1_freq_in = (req_freq_hz > dtwsl_pkg::FULL_SCALE_HZ) ?
                      dtwsl_pkg::FULL_SCALE_HZ : req_freq_hz;
         s1_side_in.control_bits = req_control_bits;
         s1_side_in.power_down   = req_power_down;
         s1_side_in.phase        = req_phase;
      end
   end

   // stage 2: quotient estimate by reciprocal multiply
   assign est_prod = {{dtwsl_pkg::TW_W{1'b0}}, s1_freq_ff}
                   * {{dtwsl_pkg::FREQ_W{1'b0}}, dtwsl_pkg::RECIP};
   always_comb begin
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s2_est_in   = adv2 ? est_prod[dtwsl_pkg::RECIP_SHIFT +: dtwsl_pkg::TW_W] : s2_est_ff;
   end

   // stage 3: low bits of estimate times divisor
   assign low_prod = {21'd0, s2_est_ff[dtwsl_pkg::REM_W-1:0]}
                   * {{dtwsl_pkg::REM_W{1'b0}}, dtwsl_pkg::DIVISOR[20:0]};
   always_comb begin
      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
      s3_low_in   = adv3 ? low_prod[dtwsl_pkg::REM_W-1:0] : s3_low_ff;
   end

   // stage 4: remainder check, bump the estimate by one if short
   // the numerator f * 2^25 has zero low bits, so the remainder is minus the product
   assign remainder = dtwsl_pkg::REM_W'(0) - s3_low_ff;
   assign round_up  = (remainder >= dtwsl_pkg::DIVISOR);
   always_comb begin
      s4_valid_in = adv4 ? s3_valid_ff : s4_valid_ff;
      s4_tw_in    = adv4 ? (s3_est_ff + dtwsl_pkg::TW_W'(round_up)) : s4_tw_ff;
   end

   // output shifter: word bits lsb first, then the update strobe
   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (ser_load) begin
         shift_in = {s4_side_ff.phase, s4_side_ff.power_down,
                     s4_side_ff.control_bits, s4_tw_ff};
         count_in = dtwsl_pkg::CNT_W'(dtwsl_pkg::RUN_LEN);
      end else if (count_ff != '0) begin
         shift_in = {1'b0, shift_ff[dtwsl_pkg::WORD_W-1:1]};
         count_in = count_ff - dtwsl_pkg::CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         count_ff    <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_freq_ff <= s1_freq_in;
      s1_side_ff <= s1_side_in;
      s2_est_ff  <= s2_est_in;
      s3_low_ff  <= s3_low_in;
      s4_tw_ff   <= s4_tw_in;
      shift_ff   <= shift_in;
      if (adv2) begin
         s2_side_ff <= s1_side_ff;
      end
      if (adv3) begin
         s3_side_ff <= s2_side_ff;
         s3_est_ff  <= s2_est_ff;
      end
      if (adv4) begin
         s4_side_ff <= s3_side_ff;
      end
   end

   // result ports
   assign rsp_valid       = (count_ff != '0);
   assign rsp_last        = (count_ff == dtwsl_pkg::CNT_W'(1));
   assign rsp_strobe_kind = rsp_last ? dtwsl_pkg::KIND_FREQ_UPDATE
                                     : dtwsl_pkg::KIND_WORD_CLOCK;
   assign rsp_serial_bit  = rsp_last ? 1'b0 : shift_ff[0];

   // checks
   a_est_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_est_ff <= 32'h8000_0000))
      else $error("quotient estimate above full scale");

   a_tw_range: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_tw_ff <= 32'h8000_0000))
      else $error("tuning word above full scale");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("result run broken before the update strobe");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_last && !ser_load) |=> !rsp_valid)
      else $error("results continue after the update strobe with nothing loaded");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> (count_ff == dtwsl_pkg::CNT_W'(dtwsl_pkg::RUN_LEN)))
      else $error("shifter load did not start a full run");

endmodule

`default_nettype wire
